[rtl/qcsv_pkg.sv]
// qcsv_pkg: shared types and constants of the quoted csv tokenizer
`default_nettype none

package qcsv_pkg;

    localparam int DEF_MAX_COLUMNS = 256;
    localparam int DEF_MAX_LINES   = 65536;

    localparam int COLUMN_W     = 9;
    localparam int LINE_FIELD_W = 17;

    localparam logic [7:0] SEPARATOR_RESET = 8'd44;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam logic [1:0] KIND_CONTENT  = 2'd0;
    localparam logic [1:0] KIND_FIELD    = 2'd1;
    localparam logic [1:0] KIND_LINE_END = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [7:0]              data_byte;
        logic [COLUMN_W-1:0]     column_index;
        logic [LINE_FIELD_W-1:0] line_index;
        logic [COLUMN_W-1:0]     max_columns;
        logic                    overflow;
        logic                    last_result;
    } out_t;

    // results of one input beat, count is 0 to 2
    typedef struct packed {
        out_t       r0;
        out_t       r1;
        logic [1:0] count;
    } pair_t;

endpackage : qcsv_pkg

`default_nettype wire

[rtl/quoted_csv_tokenizer.sv]
// quoted_csv_tokenizer: top level, separator register and channel wiring
`default_nettype none

// Splits table text, one byte per input beat, into content bytes, field ends and
// line ends, honoring quoted fields with doubled quotes. A byte is taken every
// cycle while the result buffer can take it; the parse step is a single pass from
// the accepted beat into a two-entry result buffer. A byte that yields two results
// (the line end flush on the last byte) holds off the next byte while the buffer
// drains. cfg_data sets the separator byte (reset ',') and may be written only
// while no text is in flight. Column and line counters saturate at MAX_COLUMNS
// and MAX_LINES and set the sticky overflow flag.

module quoted_csv_tokenizer #(
    parameter int MAX_COLUMNS = qcsv_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_LINES   = qcsv_pkg::DEF_MAX_LINES
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [7:0]      cfg_data,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire qcsv_pkg::in_t   in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output qcsv_pkg::out_t       out_data
);

    logic [7:0]      sep_reg;
    logic            in_beat;
    qcsv_pkg::pair_t pair;

    assign cfg_ready = 1'b1;
    assign in_beat   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg <= qcsv_pkg::SEPARATOR_RESET;
        end
        else if (cfg_valid)
        begin
            sep_reg <= cfg_data;
        end
    end

    qcsv_parse #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_LINES   (MAX_LINES)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_beat),
        .item      (in_data),
        .separator (sep_reg),
        .pair      (pair)
    );

    qcsv_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_beat),
        .pair      (pair),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule : quoted_csv_tokenizer

`default_nettype wire

[rtl/qcsv_parse.sv]
// qcsv_parse: tokenizer state and the per-byte field and line logic
`default_nettype none

module qcsv_parse #(
    parameter int MAX_COLUMNS = qcsv_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_LINES   = qcsv_pkg::DEF_MAX_LINES
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire qcsv_pkg::in_t   item,
    input  wire logic [7:0]      separator,
    output qcsv_pkg::pair_t      pair
);

    localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
    localparam int LINE_W = $clog2(MAX_LINES + 1);
    localparam int OCOL_W  = qcsv_pkg::COLUMN_W;
    localparam int OLINE_W = qcsv_pkg::LINE_FIELD_W;

    typedef struct packed {
        logic              iq;
        logic              qp;
        logic              ab;
        logic              fh;
        logic [COL_W-1:0]  col;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  wide;
        logic              ovf;
    } state_t;

    state_t state_reg;
    state_t state_next;

    state_t          s;
    state_t          nx;
    qcsv_pkg::out_t  ra;
    qcsv_pkg::out_t  rb;
    logic            has_a;
    logic            has_b;
    logic            done;
    logic            is_break;
    logic            is_quote;

    function automatic state_t end_state(state_t cur, logic line_end);
        state_t t;
        t = cur;
        if (t.col < COL_W'(MAX_COLUMNS))
        begin
            t.col = t.col + COL_W'(1);
        end
        else
        begin
            t.ovf = 1'b1;
        end
        if (t.wide < t.col)
        begin
            t.wide = t.col;
        end
        if (line_end)
        begin
            if (t.line < LINE_W'(MAX_LINES))
            begin
                t.line = t.line + LINE_W'(1);
            end
            else
            begin
                t.ovf = 1'b1;
            end
            t.col = '0;
        end
        t.fh = 1'b0;
        return t;
    endfunction

    function automatic qcsv_pkg::out_t make_res(logic [1:0] kind, logic [7:0] data,
                                                logic [COL_W-1:0] col,
                                                logic [LINE_W-1:0] line,
                                                logic [COL_W-1:0] wide, logic ovf);
        qcsv_pkg::out_t r;
        r.kind         = kind;
        r.data_byte    = data;
        r.column_index = OCOL_W'(col);
        r.line_index   = OLINE_W'(line);
        r.max_columns  = OCOL_W'(wide);
        r.overflow     = ovf;
        r.last_result  = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        s        = state_reg;
        nx       = state_reg;
        ra       = '0;
        rb       = '0;
        has_a    = 1'b0;
        has_b    = 1'b0;
        done     = 1'b0;
        is_break = (item.text_byte == qcsv_pkg::CH_LF) || (item.text_byte == qcsv_pkg::CH_CR);
        is_quote = (item.text_byte == qcsv_pkg::CH_QUOTE);

        // pending quote or absorbed break is settled by this byte first
        if (s.ab)
        begin
            s.ab = 1'b0;
            if (is_break)
            begin
                done = 1'b1;
            end
        end
        else if (s.qp)
        begin
            s.qp = 1'b0;
            if (is_quote)
            begin
                s.fh  = 1'b1;
                ra    = make_res(qcsv_pkg::KIND_CONTENT, item.text_byte, s.col, s.line,
                                 s.wide, s.ovf);
                has_a = 1'b1;
                done  = 1'b1;
            end
            else
            begin
                s.iq = 1'b0;
            end
        end

        if (!done)
        begin
            priority if (s.iq)
            begin
                s.fh = 1'b1;
                if (is_quote)
                begin
                    s.qp = 1'b1;
                end
                else
                begin
                    ra    = make_res(qcsv_pkg::KIND_CONTENT, item.text_byte, s.col, s.line,
                                     s.wide, s.ovf);
                    has_a = 1'b1;
                end
            end
            else if (is_quote)
            begin
                s.iq = 1'b1;
                s.fh = 1'b1;
            end
            else if (item.text_byte == separator)
            begin
                nx    = end_state(s, 1'b0);
                ra    = make_res(qcsv_pkg::KIND_FIELD, 8'd0, s.col, s.line, nx.wide, nx.ovf);
                s     = nx;
                has_a = 1'b1;
            end
            else if (is_break)
            begin
                nx    = end_state(s, 1'b1);
                ra    = make_res(qcsv_pkg::KIND_LINE_END, 8'd0, s.col, s.line,
                                 nx.wide, nx.ovf);
                s     = nx;
                s.ab  = 1'b1;
                has_a = 1'b1;
            end
            else
            begin
                s.fh  = 1'b1;
                ra    = make_res(qcsv_pkg::KIND_CONTENT, item.text_byte, s.col, s.line,
                                 s.wide, s.ovf);
                has_a = 1'b1;
            end
        end

        // end of text: flush a started field, then drop per-text state
        if (item.last_byte)
        begin
            if (s.fh)
            begin
                nx    = end_state(s, 1'b1);
                rb    = make_res(qcsv_pkg::KIND_LINE_END, 8'd0, s.col, s.line,
                                 nx.wide, nx.ovf);
                s     = nx;
                has_b = 1'b1;
            end
            s.iq  = 1'b0;
            s.qp  = 1'b0;
            s.ab  = 1'b0;
            s.fh  = 1'b0;
            s.col = '0;
        end

        if (has_b)
        begin
            rb.last_result = 1'b1;
        end
        else if (has_a)
        begin
            ra.last_result = 1'b1;
        end

        pair.r0    = has_a ? ra : rb;
        pair.r1    = rb;
        pair.count = {1'b0, has_a} + {1'b0, has_b};
        state_next = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.last_byte |=> !state_reg.iq && !state_reg.fh && (state_reg.col == '0))
        else $error("per-text state not cleared after last byte");
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.col <= COL_W'(MAX_COLUMNS)) && (state_reg.wide <= COL_W'(MAX_COLUMNS)))
        else $error("column counter past its limit");
`endif

endmodule : qcsv_parse

`default_nettype wire

[rtl/qcsv_obuf.sv]
// qcsv_obuf: two-entry result buffer between the parser and the output channel
`default_nettype none

module qcsv_obuf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire qcsv_pkg::pair_t  pair,
    output logic                  can_push,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output qcsv_pkg::out_t        out_data
);

    qcsv_pkg::out_t slot0_reg;
    qcsv_pkg::out_t slot1_reg;
    logic [1:0]     cnt_reg;
    logic           pop;
    logic           load;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot0_reg;
    assign pop       = out_valid && out_ready;
    // a new beat lands only in a buffer that is empty after this cycle
    assign can_push  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign load      = push && (pair.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= pair.count;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot0_reg <= pair.r0;
            slot1_reg <= pair.r1;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer count out of range");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push && (cnt_reg != 2'd0) |-> pop)
        else $error("beat pushed over a waiting result");
    a_tail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> slot0_reg.last_result)
        else $error("final buffered result not marked last");
    a_head_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !slot0_reg.last_result && slot1_reg.last_result)
        else $error("result pair marked wrongly");
`endif

endmodule : qcsv_obuf

`default_nettype wire
